/* src/lrfp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrfp_pkg
// Shared types and codes of the link retry fallback policy.
// ---------------------------------------------------------------------------
package lrfp_pkg;

   localparam logic [3:0] NET_NONE  = 4'd8;
   localparam logic [31:0] HELD_OPEN = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      KIND_RECONFIG = 3'd0,
      KIND_SET_MODE = 3'd1,
      KIND_CONNECTED = 3'd2,
      KIND_FAILED = 3'd3,
      KIND_CLIENTS = 3'd4,
      KIND_TICK = 3'd5
   } kind_type;

   localparam logic [2:0] PH_OFF        = 3'd0;
   localparam logic [2:0] PH_CONNECTING = 3'd1;
   localparam logic [2:0] PH_WAITING    = 3'd2;
   localparam logic [2:0] PH_ONLINE     = 3'd3;
   localparam logic [2:0] PH_APWINDOW   = 3'd4;
   localparam logic [2:0] PH_AP         = 3'd5;

   localparam logic [1:0] ACT_NONE         = 2'd0;
   localparam logic [1:0] ACT_STOP         = 2'd1;
   localparam logic [1:0] ACT_START_AP     = 2'd2;
   localparam logic [1:0] ACT_START_CLIENT = 2'd3;

   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_CLIENT = 2'd1;
   localparam logic [1:0] MODE_AP     = 2'd2;
   localparam logic [1:0] MODE_BAD    = 2'd3;

   localparam logic [1:0] WHY_AUTH  = 2'd1;
   localparam logic [1:0] WHY_OTHER = 2'd3;

   localparam logic [2:0] REG_NET_COUNT = 3'd0;
   localparam logic [2:0] REG_GAP       = 3'd1;
   localparam logic [2:0] REG_TIMEOUT   = 3'd2;
   localparam logic [2:0] REG_WINDOW    = 3'd3;
   localparam logic [2:0] REG_ROUNDS    = 3'd4;
   localparam logic [2:0] REG_BACKOFF   = 3'd5;
   localparam logic [2:0] REG_MAX_BO    = 3'd6;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now_ms;
      logic [1:0]  mode_request;
      logic [1:0]  fail_reason;
      logic [7:0]  client_count;
   } event_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  link_state;
      logic [3:0]  network_index;
      logic [1:0]  last_failure;
      logic [7:0]  auth_fail_mask;
      logic [31:0] window_left_ms;
      logic [31:0] wait_left_ms;
      logic        no_candidates;
      logic [7:0]  round_count;
   } result_type;

   // Controller -> datapath.
   typedef struct packed {
      logic load;      // capture event, compute backoff product
      logic update;    // apply event to the policy state
      logic report;    // form the result beat
   } dp_cmd_type;

   typedef struct packed {
      logic done;
   } dp_stat_type;

endpackage

/* src/lrfp_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrfp_ctrl
// Sequencer: accept a beat, step the datapath, hold the result beat.
// ---------------------------------------------------------------------------
module lrfp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lrfp_pkg::dp_cmd_type  cmd,
   input  lrfp_pkg::dp_stat_type stat
);
   import lrfp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE, ST_UPDATE, ST_REPORT, ST_SEND
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (in_valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_REPORT;
         ST_REPORT: state_in = ST_SEND;
         ST_SEND:   if (out_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_ready    = (state_ff == ST_IDLE);
   assign out_valid   = (state_ff == ST_SEND) && stat.done;
   assign cmd.load    = (state_ff == ST_IDLE) && in_valid;
   assign cmd.update  = (state_ff == ST_UPDATE);
   assign cmd.report  = (state_ff == ST_REPORT);

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.update) else $error("update did not follow load");
   a_report: assert property (@(posedge clock) disable iff (reset)
      cmd.report |=> out_valid) else $error("result not offered");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

/* src/lrfp_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrfp_datapath
// Policy state, candidate search, timers and backoff multiply.
// ---------------------------------------------------------------------------
module lrfp_datapath #(
   parameter int MAX_NETS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lrfp_pkg::dp_cmd_type  cmd,
   output lrfp_pkg::dp_stat_type stat,
   input  lrfp_pkg::event_type   ev,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output lrfp_pkg::result_type  res
);
   import lrfp_pkg::*;

   // configuration
   logic [3:0]  net_cnt_ff;
   logic [31:0] gap_ff, timeout_ff, window_ff, backoff_ff, maxbo_ff;
   logic [7:0]  rounds_ff;

   // policy state
   logic [1:0]  desired_ff;
   logic [2:0]  phase_ff;
   logic [3:0]  cur_ff, good_ff;
   logic [7:0]  done_ff, clients_ff, mask_ff;
   logic [1:0]  pend_ff, fail_ff;
   logic [31:0] att_start_ff, wait_start_ff, wait_len_ff, win_start_ff;

   event_type   ev_ff;
   logic [39:0] prod_ff;
   result_type  res_ff;

   logic [3:0] n_eff;
   assign n_eff = (net_cnt_ff > 4'(MAX_NETS)) ? 4'(MAX_NETS) : net_cnt_ff;

   function automatic logic [3:0] next_from(input logic [3:0] start, input logic [3:0] n,
                                            input logic [7:0] m);
      logic [3:0] r;
      r = NET_NONE;
      for (int i = MAX_NETS - 1; i >= 0; i--) begin
         if (4'(i) >= start && 4'(i) < n && !m[i]) r = 4'(i);
      end
      return r;
   endfunction

   function automatic logic bad_net(input logic [3:0] c, input logic [3:0] n,
                                    input logic [7:0] m);
      return (c >= n) || (c < 4'd8 && m[c[2:0]]);
   endfunction

   // saturated round+1 used by advance; product of backoff with it
   logic [7:0] round_inc;
   assign round_inc = (done_ff == 8'hFF) ? done_ff : done_ff + 8'd1;

   logic [31:0] el_att, el_wait, el_win, win_left;
   assign el_att  = ev_ff.now_ms - att_start_ff;
   assign el_wait = ev_ff.now_ms - wait_start_ff;
   assign el_win  = ev_ff.now_ms - win_start_ff;
   assign win_left = (clients_ff != 8'd0 || n_eff == 4'd0) ? HELD_OPEN :
                     (el_win >= window_ff) ? 32'd0 : window_ff - el_win;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ev_ff   <= ev;
         prod_ff <= backoff_ff * round_inc;
      end
   end

   // next-state of the policy, computed during update
   logic [1:0]  desired_in, pend_in, fail_in, act_in;
   logic [2:0]  phase_in;
   logic [3:0]  cur_in, good_in, nx;
   logic [7:0]  done_in, clients_in, mask_in;
   logic [31:0] att_in, wstart_in, wlen_in, win_in, bo;

   always_comb begin
      desired_in = desired_ff; phase_in = phase_ff; cur_in = cur_ff; good_in = good_ff;
      done_in = done_ff; pend_in = pend_ff; fail_in = fail_ff; clients_in = clients_ff;
      mask_in = mask_ff; att_in = att_start_ff; wstart_in = wait_start_ff;
      wlen_in = wait_len_ff; win_in = win_start_ff; act_in = ACT_NONE; nx = NET_NONE;
      bo = (prod_ff > {8'd0, maxbo_ff}) ? maxbo_ff : prod_ff[31:0];
      // start flags
      begin : policy
         logic do_attempt, do_advance, do_window;
         do_attempt = 1'b0; do_advance = 1'b0; do_window = 1'b0;
         case (ev_ff.kind)
            KIND_RECONFIG: begin
               mask_in = 8'd0; good_in = NET_NONE; done_in = 8'd0;
               if (desired_ff == MODE_CLIENT) begin
                  cur_in = NET_NONE; do_attempt = 1'b1;
               end
            end
            KIND_SET_MODE: begin
               if (ev_ff.mode_request != MODE_BAD && ev_ff.mode_request != desired_ff) begin
                  desired_in = ev_ff.mode_request;
                  if (ev_ff.mode_request == MODE_OFF) begin
                     phase_in = PH_OFF; cur_in = NET_NONE; done_in = 8'd0; pend_in = ACT_STOP;
                  end else if (ev_ff.mode_request == MODE_AP) begin
                     phase_in = PH_AP; clients_in = 8'd0; pend_in = ACT_START_AP;
                  end else begin
                     done_in = 8'd0; cur_in = good_ff; do_attempt = 1'b1;
                  end
               end
            end
            KIND_CONNECTED: begin
               if (phase_ff == PH_CONNECTING) begin
                  phase_in = PH_ONLINE; fail_in = 2'd0; good_in = cur_ff; done_in = 8'd0;
                  if (cur_ff < 4'd8) mask_in[cur_ff[2:0]] = 1'b0;
               end
            end
            KIND_FAILED: begin
               fail_in = ev_ff.fail_reason;
               if (phase_ff == PH_ONLINE) begin
                  done_in = 8'd0; cur_in = good_ff; phase_in = PH_WAITING;
                  wstart_in = ev_ff.now_ms; wlen_in = gap_ff;
               end else if (phase_ff == PH_CONNECTING) begin
                  if (ev_ff.fail_reason == WHY_AUTH && cur_ff < 4'd8)
                     mask_in[cur_ff[2:0]] = 1'b1;
                  do_advance = 1'b1;
               end
            end
            KIND_CLIENTS: begin
               clients_in = ev_ff.client_count;
               if (phase_ff == PH_APWINDOW && clients_ff != 8'd0 && ev_ff.client_count == 8'd0)
                  win_in = ev_ff.now_ms;
            end
            KIND_TICK: begin
               if (phase_ff == PH_CONNECTING) begin
                  if (el_att >= timeout_ff) begin
                     fail_in = WHY_OTHER; do_advance = 1'b1;
                  end
               end else if (phase_ff == PH_WAITING) begin
                  if (el_wait >= wait_len_ff) do_attempt = 1'b1;
               end else if (phase_ff == PH_APWINDOW) begin
                  if (win_left == 32'd0) begin
                     mask_in = 8'd0; done_in = 8'd0; cur_in = NET_NONE; do_attempt = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         if (do_advance) begin
            nx = (cur_ff >= NET_NONE) ? NET_NONE : next_from(cur_ff + 4'd1, n_eff, mask_in);
            if (nx != NET_NONE) begin
               cur_in = nx; phase_in = PH_WAITING; wstart_in = ev_ff.now_ms; wlen_in = gap_ff;
            end else begin
               done_in = round_inc;
               if (round_inc >= rounds_ff || next_from(4'd0, n_eff, mask_in) == NET_NONE) begin
                  do_window = 1'b1;
               end else begin
                  cur_in = next_from(4'd0, n_eff, mask_in); phase_in = PH_WAITING;
                  wstart_in = ev_ff.now_ms; wlen_in = bo;
               end
            end
         end
         if (do_attempt) begin
            if (bad_net(cur_in, n_eff, mask_in)) cur_in = next_from(4'd0, n_eff, mask_in);
            if (cur_in == NET_NONE) begin
               do_window = 1'b1;
            end else begin
               phase_in = PH_CONNECTING; att_in = ev_ff.now_ms; pend_in = ACT_START_CLIENT;
            end
         end
         if (do_window) begin
            phase_in = PH_APWINDOW; win_in = ev_ff.now_ms; clients_in = 8'd0;
            pend_in = ACT_START_AP;
         end
         if (ev_ff.kind == KIND_TICK) begin
            act_in = pend_in; pend_in = ACT_NONE;
         end
      end
   end

   logic [1:0] act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         net_cnt_ff <= 4'd0; gap_ff <= 32'd2000; timeout_ff <= 32'd15000;
         window_ff <= 32'd300000; rounds_ff <= 8'd3; backoff_ff <= 32'd5000;
         maxbo_ff <= 32'd60000;
         desired_ff <= MODE_OFF; phase_ff <= PH_OFF; cur_ff <= NET_NONE; good_ff <= NET_NONE;
         done_ff <= 8'd0; pend_ff <= ACT_NONE; fail_ff <= 2'd0; clients_ff <= 8'd0;
         mask_ff <= 8'd0; att_start_ff <= 32'd0; wait_start_ff <= 32'd0;
         wait_len_ff <= 32'd0; win_start_ff <= 32'd0; act_ff <= ACT_NONE;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_NET_COUNT: net_cnt_ff <= csr_wdata[3:0];
               REG_GAP:       gap_ff <= csr_wdata;
               REG_TIMEOUT:   timeout_ff <= csr_wdata;
               REG_WINDOW:    window_ff <= csr_wdata;
               REG_ROUNDS:    rounds_ff <= csr_wdata[7:0];
               REG_BACKOFF:   backoff_ff <= csr_wdata;
               REG_MAX_BO:    maxbo_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.update) begin
            desired_ff <= desired_in; phase_ff <= phase_in; cur_ff <= cur_in;
            good_ff <= good_in; done_ff <= done_in; pend_ff <= pend_in; fail_ff <= fail_in;
            clients_ff <= clients_in; mask_ff <= mask_in; att_start_ff <= att_in;
            wait_start_ff <= wstart_in; wait_len_ff <= wlen_in; win_start_ff <= win_in;
            act_ff <= act_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         res_ff.action         <= act_ff;
         res_ff.link_state     <= phase_ff;
         res_ff.network_index  <= cur_ff;
         res_ff.last_failure   <= fail_ff;
         res_ff.auth_fail_mask <= mask_ff;
         res_ff.window_left_ms <= (phase_ff == PH_APWINDOW) ? win_left : 32'd0;
         res_ff.wait_left_ms   <= (phase_ff == PH_WAITING) ?
                                  ((el_wait >= wait_len_ff) ? 32'd0 : wait_len_ff - el_wait)
                                  : 32'd0;
         res_ff.no_candidates  <= (next_from(4'd0, n_eff, mask_ff) == NET_NONE);
         res_ff.round_count    <= done_ff;
      end
   end

   logic done_ff2;
   always_ff @(posedge clock) begin
      if (reset) done_ff2 <= 1'b0;
      else if (cmd.report) done_ff2 <= 1'b1;
      else if (cmd.load) done_ff2 <= 1'b0;
   end
   assign stat.done = done_ff2;
   assign res = res_ff;

   a_net_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= NET_NONE) else $error("network index out of range");
   a_conn_net: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CONNECTING) |-> (cur_ff < NET_NONE)) else $error("connect with no net");
   a_off_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OFF && desired_ff == MODE_OFF) |-> cur_ff == NET_NONE)
      else $error("off with a network chosen");
endmodule

/* src/link_retry_fallback_policy.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// link_retry_fallback_policy
// Retry and fallback policy for a wireless link, one result beat per event.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ channel: one event beat (kind, time stamp, mode, reason, clients).
//  - rsp_ channel: exactly one result beat per event, the state after it.
//  - csr_ port: write registers 0..6 while the block is idle; live at once.
// Timing: the event is captured at its accepting edge (with the backoff
// multiply), then the policy state updates, then the result is formed
// and the result beat is offered. The next event is taken only once the
// result beat has left, so a new event is not accepted before the last
// one is through. Events are handled one at a time through the shared
// policy state.
// Reset: synchronous, active high; registers take their documented defaults,
// the link is off and no network is selected.
// Stall: while rsp_tready is low the result beat holds and req_tready stays
// low; nothing is lost.
// ---------------------------------------------------------------------------
module link_retry_fallback_policy #(
   parameter int MAX_NETS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // kind, now_ms, mode_request, fail_reason, client_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // action, link_state, network_index, last_failure, auth_fail_mask,
   // window_left_ms, wait_left_ms, no_candidates, round_count
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import lrfp_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   event_type   ev;
   result_type  res;

   // unpack the request beat, first field lowest
   assign ev.kind         = req_tdata[2:0];
   assign ev.now_ms       = req_tdata[34:3];
   assign ev.mode_request = req_tdata[36:35];
   assign ev.fail_reason  = req_tdata[38:37];
   assign ev.client_count = req_tdata[46:39];

   lrfp_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd, .stat
   );

   lrfp_datapath #(.MAX_NETS(MAX_NETS)) u_dp (
      .clock, .reset, .cmd, .stat, .ev,
      .csr_we, .csr_index, .csr_wdata, .res
   );

   // pack the result beat, first field lowest, zero fill to whole bytes
   assign rsp_tdata = {4'd0, res.round_count, res.no_candidates, res.wait_left_ms,
                       res.window_left_ms, res.auth_fail_mask, res.last_failure,
                       res.network_index, res.link_state, res.action};
endmodule
